### design/brightness_residency_histogram_top_macros.svh
// ---------------------------------------------------------------------------
// brightness residency histogram assertion macros
// shared assertion forms used by the port checker
// ---------------------------------------------------------------------------
`ifndef BRIGHTNESS_RESIDENCY_HISTOGRAM_TOP_MACROS_SVH
`define BRIGHTNESS_RESIDENCY_HISTOGRAM_TOP_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define BRH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("brh same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define BRH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("brh next-cycle check failed");

`endif

### design/brh_pkg.sv
// ---------------------------------------------------------------------------
// brh_pkg
// types and constants shared by the brightness residency histogram
// ---------------------------------------------------------------------------
package brh_pkg;

	localparam int BINS    = 10;
	localparam int BIN_W   = 4;
	localparam int LEVEL_W = 16;
	localparam int TIME_W  = 64;
	localparam int ACT_W   = 2;
	localparam int IDX_W   = (BINS > 1) ? $clog2(BINS) : 1;
	// quotient never reaches BINS, so IDX_W bits hold it
	localparam int QUO_W   = IDX_W;
	localparam int KW      = (QUO_W > 1) ? $clog2(QUO_W) : 1;
	localparam int DIV_W   = LEVEL_W + 1;
	localparam int REM_W   = LEVEL_W + QUO_W + 1;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_SET   = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	// controller to datapath
	typedef struct packed {
		logic             capture;
		logic             prep;
		logic             div_step;
		logic [KW-1:0]    div_k;
		logic             update;
		logic             load_set;
		logic             load_read;
		logic [IDX_W-1:0] rd_idx;
		logic             load_clear;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

### design/brh_datapath.sv
// ---------------------------------------------------------------------------
// brh_datapath
// clamp, serial bin divider, bin totals, active bin tracking, output register
// ---------------------------------------------------------------------------
module brh_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  brh_pkg::cmd_t                     cmd,
	output brh_pkg::stat_t                    stat,
	input  logic [brh_pkg::LEVEL_W-1:0]       in_level,
	input  logic [brh_pkg::TIME_W-1:0]        in_now,
	input  logic                              cfg_valid,
	input  logic [brh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [brh_pkg::LEVEL_W-1:0]       cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [brh_pkg::BIN_W-1:0]         out_bin_index,
	output logic [brh_pkg::TIME_W-1:0]        out_bin_time,
	output logic                              out_clamped,
	output logic                              out_last
);
	import brh_pkg::*;

	logic [LEVEL_W-1:0] min_q, max_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0]  now_q;
	logic [DIV_W-1:0]   d_q;
	logic [REM_W-1:0]   rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic               clamp_q;
	logic [TIME_W-1:0]  delta_q;
	logic [TIME_W-1:0]  total_q [BINS];
	logic [TIME_W-1:0]  start_q;
	logic [BIN_W-1:0]   active_q;
	logic               act_valid_q;

	logic               out_valid_q;
	logic [BIN_W-1:0]   out_idx_q;
	logic [TIME_W-1:0]  out_time_q;
	logic               out_clamp_q;
	logic               out_last_q;

	logic [LEVEL_W-1:0] hi, lvl_c, x;
	logic               clamp_c;
	logic [REM_W-1:0]   sub;
	logic [BIN_W-1:0]   bin_sel;
	logic [TIME_W-1:0]  rd_sum;
	logic               out_free;

	// range collapses to min when max is below it
	always_comb begin
		hi      = (max_q < min_q) ? min_q : max_q;
		clamp_c = 1'b0;
		lvl_c   = level_q;
		if (level_q > hi) begin
			lvl_c   = hi;
			clamp_c = 1'b1;
		end else if (level_q < min_q) begin
			lvl_c   = min_q;
			clamp_c = 1'b1;
		end
		x = lvl_c - min_q;
	end

	assign sub = REM_W'(d_q) << cmd.div_k;

	assign bin_sel = (quo_q >= QUO_W'(BINS)) ? BIN_W'(BINS - 1) : BIN_W'(quo_q);

	always_comb begin
		rd_sum = total_q[cmd.rd_idx];
		if (act_valid_q && (active_q == BIN_W'(cmd.rd_idx)))
			rd_sum = total_q[cmd.rd_idx] + delta_q;
	end

	assign out_free      = !out_valid_q || out_ready;
	assign stat.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= LEVEL_W'(255);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_LEVEL: min_q <= cfg_data;
				REG_MAX_LEVEL: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture and division work registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			level_q <= in_level;
			now_q   <= in_now;
		end
		if (cmd.prep) begin
			d_q     <= DIV_W'({1'b0, hi} - {1'b0, min_q} + 1'b1);
			rem_q   <= REM_W'(BINS) * REM_W'(x);
			quo_q   <= '0;
			clamp_q <= clamp_c;
			delta_q <= now_q - start_q;
		end else if (cmd.div_step) begin
			if (rem_q >= sub) begin
				rem_q             <= rem_q - sub;
				quo_q[cmd.div_k]  <= 1'b1;
			end
		end
		if (cmd.update && (!act_valid_q || active_q != bin_sel))
			start_q <= now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BINS; i++)
				total_q[i] <= '0;
			active_q    <= '0;
			act_valid_q <= 1'b0;
		end else if (cmd.load_clear) begin
			for (int i = 0; i < BINS; i++)
				total_q[i] <= '0;
			active_q    <= '0;
			act_valid_q <= 1'b0;
		end else if (cmd.update && (!act_valid_q || active_q != bin_sel)) begin
			// close the old bin before opening the new one
			if (act_valid_q)
				total_q[active_q[IDX_W-1:0]] <= total_q[active_q[IDX_W-1:0]] + delta_q;
			active_q    <= bin_sel;
			act_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_set || cmd.load_read || cmd.load_clear) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_set) begin
			out_idx_q   <= bin_sel;
			out_time_q  <= '0;
			out_clamp_q <= clamp_q;
			out_last_q  <= 1'b1;
		end else if (cmd.load_read) begin
			out_idx_q   <= BIN_W'(cmd.rd_idx);
			out_time_q  <= rd_sum;
			out_clamp_q <= 1'b0;
			out_last_q  <= (cmd.rd_idx == IDX_W'(BINS - 1));
		end else if (cmd.load_clear) begin
			out_idx_q   <= '0;
			out_time_q  <= '0;
			out_clamp_q <= 1'b0;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_bin_index = out_idx_q;
	assign out_bin_time  = out_time_q;
	assign out_clamped   = out_clamp_q;
	assign out_last      = out_last_q;

endmodule

### design/brh_ctrl.sv
// ---------------------------------------------------------------------------
// brh_ctrl
// sequencer for set, read and clear requests
// ---------------------------------------------------------------------------
module brh_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [brh_pkg::ACT_W-1:0]   in_action,
	input  brh_pkg::stat_t              stat,
	output brh_pkg::cmd_t               cmd
);
	import brh_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_PREP    = 7'b0000010,
		S_DIV     = 7'b0000100,
		S_UPD     = 7'b0001000,
		S_SET_OUT = 7'b0010000,
		S_READ    = 7'b0100000,
		S_CLR_OUT = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic             rd_mode_q, rd_mode_d;
	logic [KW-1:0]    div_cnt_q, div_cnt_d;
	logic [IDX_W-1:0] rd_cnt_q, rd_cnt_d;
	logic             accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d   = state_q;
		rd_mode_d = rd_mode_q;
		div_cnt_d = div_cnt_q;
		rd_cnt_d  = rd_cnt_q;
		cmd       = '0;
		cmd.div_k  = div_cnt_q;
		cmd.rd_idx = rd_cnt_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = accept;
				if (accept) begin
					case (action_t'(in_action))
						ACT_SET: begin
							rd_mode_d = 1'b0;
							state_d   = S_PREP;
						end
						ACT_READ: begin
							rd_mode_d = 1'b1;
							state_d   = S_PREP;
						end
						ACT_CLEAR: state_d = S_CLR_OUT;
						default: ;
					endcase
				end
			end
			S_PREP: begin
				cmd.prep  = 1'b1;
				div_cnt_d = KW'(QUO_W - 1);
				rd_cnt_d  = '0;
				state_d   = rd_mode_q ? S_READ : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == '0)
					state_d = S_UPD;
				else
					div_cnt_d = div_cnt_q - 1'b1;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_SET_OUT;
			end
			S_SET_OUT: begin
				if (stat.out_free) begin
					cmd.load_set = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_READ: begin
				if (stat.out_free) begin
					cmd.load_read = 1'b1;
					if (rd_cnt_q == IDX_W'(BINS - 1))
						state_d = S_IDLE;
					else
						rd_cnt_d = rd_cnt_q + 1'b1;
				end
			end
			S_CLR_OUT: begin
				if (stat.out_free) begin
					cmd.load_clear = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_mode_q <= 1'b0;
			div_cnt_q <= '0;
			rd_cnt_q  <= '0;
		end else begin
			state_q   <= state_d;
			rd_mode_q <= rd_mode_d;
			div_cnt_q <= div_cnt_d;
			rd_cnt_q  <= rd_cnt_d;
		end
	end

endmodule

### design/brightness_residency_histogram_top.sv
// ---------------------------------------------------------------------------
// brightness_residency_histogram_top
// time spent per brightness bin, with set, read and clear requests
// ---------------------------------------------------------------------------
//  channel   direction  handshake             carries
//  s_*       in         s_tvalid / s_tready   request: action, level, now
//  m_*       out        m_tvalid / m_tready   result: bin_index, bin_time, clamped, last
//  cfg_*     in         cfg_valid / cfg_ready min_level, max_level writes
//
//  set runs from accept to result through capture, prepare, 4 divider steps
//  of the bin quotient, bin update and output load.
//  read runs capture, prepare, then one output load per bin, paced by the output register.
//  clear runs capture, then output load; one request is in flight at a time.
//  a full output register stalls the sequencer; the next request is taken when it is idle.
//  arst_n clears all bin totals and the active bin at once.
module brightness_residency_histogram_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [79:0]                     s_tdata,   // level[15:0], now[79:16]
	input  logic [brh_pkg::ACT_W-1:0]       s_tuser,   // action[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [71:0]                     m_tdata,   // bin_index[3:0], bin_time[67:4], zero
	output logic                            m_tuser,   // clamped
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [brh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brh_pkg::LEVEL_W-1:0]     cfg_data
);
	import brh_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	logic [BIN_W-1:0]   bin_index;
	logic [TIME_W-1:0]  bin_time;

	assign cfg_ready = 1'b1;

	brh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.stat      (stat),
		.cmd       (cmd)
	);

	brh_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_level      (s_tdata[LEVEL_W-1:0]),
		.in_now        (s_tdata[LEVEL_W +: TIME_W]),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_bin_index (bin_index),
		.out_bin_time  (bin_time),
		.out_clamped   (m_tuser),
		.out_last      (m_tlast)
	);

	assign m_tdata = {4'b0000, bin_time, bin_index};

endmodule

### design/brh_checker.sv
// ---------------------------------------------------------------------------
// brh_checker
// port-level checks on the result stream of the histogram
// ---------------------------------------------------------------------------
`include "brightness_residency_histogram_top_macros.svh"

module brh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	import brh_pkg::*;

	// a stalled result stays offered and unchanged
	`BRH_ASSERT_NXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`BRH_ASSERT_NXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// a clamped flag only comes with a single set result
	`BRH_ASSERT_NOW(a_clamp_last, clk, arst_n, m_tvalid && m_tuser, m_tlast && (m_tdata[67:4] == '0))

	// readout results before the final one never reach the top bin
	`BRH_ASSERT_NOW(a_read_order, clk, arst_n, m_tvalid && !m_tlast, m_tdata[3:0] < BIN_W'(BINS - 1))

endmodule

bind brightness_residency_histogram_top brh_checker u_brh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

### bench/brightness_residency_histogram_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// brightness_residency_histogram_top_tb
// drives set, read and clear requests through the residency histogram and
// checks every result against a bin-time predictor, with random idling on
// both streams and the level range moved between phases
// ---------------------------------------------------------------------------
module brightness_residency_histogram_top_tb;
	import brh_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		logic [BIN_W-1:0]  bin_index;
		logic [TIME_W-1:0] bin_time;
		logic              clamped;
		logic              last;
	} bin_report_t;

	// residency predictor plus queue of bin reports still owed by the block
	class residency_scoreboard;
		logic [LEVEL_W-1:0] min_level;
		logic [LEVEL_W-1:0] max_level;
		logic [TIME_W-1:0]  bin_total[BINS];
		logic [TIME_W-1:0]  bin_start[BINS];
		int unsigned        active_bin;
		bit                 active_valid;
		bin_report_t        owed_reports[$];
		int                 errors;

		function new();
			min_level = 16'd0;
			max_level = 16'd255;
			active_bin = 0;
			active_valid = 1'b0;
			errors = 0;
			foreach (bin_total[i]) begin
				bin_total[i] = '0;
				bin_start[i] = '0;
			end
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
			if (idx == REG_MIN_LEVEL)
				min_level = val;
			else
				max_level = val;
		endfunction

		function int pending();
			return owed_reports.size();
		endfunction

		function void note_request(logic [ACT_W-1:0] act, logic [LEVEL_W-1:0] lvl,
				logic [TIME_W-1:0] stamp);
			int unsigned lo, hi, v, bin;
			bin_report_t r;
			r.bin_time = '0;
			r.clamped = 1'b0;
			r.last = 1'b1;
			r.bin_index = '0;
			if (act == ACT_SET) begin
				lo = 32'(min_level);
				hi = (max_level < min_level) ? 32'(min_level) : 32'(max_level);
				v = 32'(lvl);
				if (v > hi) begin
					v = hi;
					r.clamped = 1'b1;
				end else if (v < lo) begin
					v = lo;
					r.clamped = 1'b1;
				end
				bin = (BINS * (v - lo)) / (hi - lo + 1);
				if (bin >= BINS)
					bin = BINS - 1;
				if (!active_valid || active_bin != bin) begin
					if (active_valid)
						bin_total[active_bin] += stamp - bin_start[active_bin];
					bin_start[bin] = stamp;
					active_bin = bin;
					active_valid = 1'b1;
				end
				r.bin_index = bin[BIN_W-1:0];
				owed_reports.push_back(r);
			end else if (act == ACT_READ) begin
				for (int i = 0; i < BINS; i++) begin
					r.bin_index = i[BIN_W-1:0];
					r.bin_time = bin_total[i];
					if (active_valid && active_bin == i)
						r.bin_time += stamp - bin_start[i];
					r.last = (i == BINS - 1);
					owed_reports.push_back(r);
				end
			end else if (act == ACT_CLEAR) begin
				foreach (bin_total[i]) begin
					bin_total[i] = '0;
					bin_start[i] = '0;
				end
				active_bin = 0;
				active_valid = 1'b0;
				owed_reports.push_back(r);
			end
			// unused action: no state change, no result
		endfunction

		function void check_result(logic [BIN_W-1:0] idx, logic [TIME_W-1:0] t,
				logic cl, logic lst);
			bin_report_t e;
			if (owed_reports.size() == 0) begin
				$error("unexpected result: bin_index %0d bin_time %0d", idx, t);
				errors++;
				return;
			end
			e = owed_reports.pop_front();
			if (idx !== e.bin_index) begin
				$error("bin_index mismatch: expected %0d, actual %0d", e.bin_index, idx);
				errors++;
			end
			if (t !== e.bin_time) begin
				$error("bin_time mismatch: expected %0d, actual %0d", e.bin_time, t);
				errors++;
			end
			if (cl !== e.clamped) begin
				$error("clamped mismatch: expected %0d, actual %0d", e.clamped, cl);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last mismatch: expected %0d, actual %0d", e.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [79:0]          s_tdata = '0;
	logic [ACT_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [71:0]          m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEVEL_W-1:0]   cfg_data = '0;

	residency_scoreboard sb = new();

	bit                 steady = 1'b0;    // no idling on either side
	bit                 hold_off = 1'b0;  // receiver takes one long stall
	logic [TIME_W-1:0]  wall_ns = 64'd0;
	logic [LEVEL_W-1:0] cur_min = 16'd0;
	logic [LEVEL_W-1:0] cur_max = 16'd255;

	brightness_residency_histogram_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// called right after the clock rises; returns once the block has taken the request
	task automatic send_request(logic [ACT_W-1:0] act, logic [LEVEL_W-1:0] lvl,
			logic [TIME_W-1:0] stamp);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {stamp, lvl};
		s_tuser <= act;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_request(act, lvl, stamp);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_register(idx, val);
	endtask

	// registers move only once the block has gone quiet
	task automatic set_range(logic [LEVEL_W-1:0] lo, logic [LEVEL_W-1:0] hi);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_register(REG_MIN_LEVEL, lo);
		write_register(REG_MAX_LEVEL, hi);
		cfg_valid <= 1'b0;
		cur_min = lo;
		cur_max = hi;
	endtask

	// returns 1 when the request counts toward the phase size
	task automatic random_request(output bit counted);
		int pick, lsel, tsel;
		logic [ACT_W-1:0]   act;
		logic [LEVEL_W-1:0] lvl, hi;
		logic [TIME_W-1:0]  stamp;
		pick = $urandom_range(0, 99);
		if (pick < 68)
			act = ACT_SET;
		else if (pick < 84)
			act = ACT_READ;
		else if (pick < 92)
			act = ACT_CLEAR;
		else
			act = ACT_UNUSED;
		hi = (cur_max < cur_min) ? cur_min : cur_max;
		lsel = $urandom_range(0, 9);
		if (lsel < 7)
			lvl = LEVEL_W'($urandom_range(hi, cur_min));
		else if (lsel == 7)
			lvl = LEVEL_W'($urandom_range(cur_min, 0));
		else if (lsel == 8)
			lvl = LEVEL_W'($urandom_range(16'hffff, hi));
		else
			lvl = LEVEL_W'($urandom());
		tsel = $urandom_range(0, 19);
		if (tsel == 0) begin
			stamp = {$urandom(), $urandom()};
		end else if (tsel == 1) begin
			// clock stepping back
			stamp = wall_ns - TIME_W'($urandom_range(1, 2000000));
		end else begin
			wall_ns += TIME_W'($urandom_range(1, 1000000));
			stamp = wall_ns;
		end
		send_request(act, lvl, stamp);
		counted = (act != ACT_UNUSED);
	endtask

	initial begin : result_sink
		int gap;
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = steady ? 0 : $urandom_range(0, 10);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			sb.check_result(m_tdata[3:0], m_tdata[67:4], m_tuser, m_tlast);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [LEVEL_W-1:0] ranges[6][2];
		int phase_size;
		int done;
		bit counted;
		ranges = '{'{16'd0, 16'd65535}, '{16'd5, 16'd14}, '{16'd1000, 16'd1009},
			'{16'd0, 16'd0}, '{16'd200, 16'd50}, '{16'd0, 16'd255}};
		phase_size = 38;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset range 0..255
		send_request(ACT_READ, 16'd0, 64'd500);
		send_request(ACT_SET, 16'd0, 64'd1000);
		send_request(ACT_SET, 16'd255, 64'd3000);
		send_request(ACT_SET, 16'd250, 64'd3500);
		send_request(ACT_SET, 16'hffff, 64'd4000);
		send_request(ACT_READ, 16'd0, 64'd5000);
		send_request(ACT_SET, 16'd128, 64'd4500);
		send_request(ACT_SET, 16'd26, 64'd100);
		send_request(ACT_READ, 16'hffff, 64'hffff_ffff_ffff_ffff);
		send_request(ACT_UNUSED, 16'hffff, 64'hffff_ffff_ffff_ffff);
		send_request(ACT_CLEAR, 16'hffff, 64'hffff_ffff_ffff_ffff);
		send_request(ACT_READ, 16'd0, 64'd0);
		send_request(ACT_SET, 16'd255, 64'hffff_ffff_ffff_ffff);
		send_request(ACT_SET, 16'd0, 64'd0);
		send_request(ACT_READ, 16'd0, 64'd77);

		// max below min collapses the range to min
		set_range(16'd300, 16'd100);
		send_request(ACT_SET, 16'd300, 64'd10);
		send_request(ACT_SET, 16'd299, 64'd20);
		send_request(ACT_SET, 16'hffff, 64'd30);
		send_request(ACT_READ, 16'd0, 64'd40);

		set_range(16'hffff, 16'hffff);
		send_request(ACT_SET, 16'hffff, 64'd50);
		send_request(ACT_SET, 16'd0, 64'd60);
		send_request(ACT_READ, 16'd0, 64'd70);

		set_range(16'd0, 16'hffff);
		send_request(ACT_SET, 16'hffff, 64'd80);
		send_request(ACT_SET, 16'd6553, 64'd90);
		send_request(ACT_READ, 16'd0, 64'd100);

		for (int p = 0; p < 7; p++) begin
			if (p < 6)
				set_range(ranges[p][0], ranges[p][1]);
			else
				set_range(LEVEL_W'($urandom()), LEVEL_W'($urandom()));
			steady = (p % 3 == 2);
			hold_off = (p == 1 || p == 4);
			wall_ns = {$urandom_range(0, 15), $urandom()};
			done = 0;
			while (done < phase_size - 6) begin
				random_request(counted);
				if (counted)
					done++;
			end
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
